// File: hdl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the stable minimum priority queue: beat
// payloads, operation and status codes, controller states and the
// controller-to-datapath command group.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] entry_value;
        logic signed [31:0] entry_rank;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] head_value;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // apply the operation and fill the result register
    } t_dp_cmd;

endpackage

// File: hdl/smpq_ctrl.sv
// ----------------------------------------------------------------------------
// smpq_ctrl
// Controller: accepts one input beat, runs its execute state and owns the
// result valid flag, stalling execution while the previous result waits.
// ----------------------------------------------------------------------------
module smpq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output smpq_pkg::t_dp_cmd o_cmd
);
    import smpq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                // hold the result register until the waiting beat is taken
                o_cmd.exec = w_out_free;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/smpq_dpath.sv
// ----------------------------------------------------------------------------
// smpq_dpath
// Datapath: a sorted row of slots with per-slot rank compare and a parallel
// shift for insert and remove, the entry count and the result register.
// ----------------------------------------------------------------------------
module smpq_dpath #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smpq_pkg::t_dp_cmd   i_cmd,
    input  smpq_pkg::t_in_item  i_in_item,
    output smpq_pkg::t_out_item o_out_item
);
    import smpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_in_item                r_item;
    t_out_item               r_out;
    t_out_item               n_out;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [VALUE_WIDTH-1:0]  r_slot_value [CAPACITY];
    logic signed [31:0]      r_slot_rank  [CAPACITY];
    logic [VALUE_WIDTH-1:0]  n_slot_value [CAPACITY];
    logic signed [31:0]      n_slot_rank  [CAPACITY];
    logic [CAPACITY-1:0]     w_le;
    logic [VALUE_WIDTH-1:0]  w_new_value;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_do_insert;
    logic                    w_do_remove;

    assign w_new_value = VALUE_WIDTH'(r_item.entry_value);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_do_insert = i_cmd.exec && (r_item.opcode == OP_INSERT) && !w_full;
    assign w_do_remove = i_cmd.exec && (r_item.opcode == OP_REMOVE) && !w_empty;

    // Slots holding a rank <= the new key form a prefix; the new entry lands
    // right behind it and everything after moves back one place.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        assign w_le[g] = (CW'(g) < r_count) && (r_slot_rank[g] <= r_item.entry_rank);

        always_comb begin
            n_slot_value[g] = r_slot_value[g];
            n_slot_rank[g]  = r_slot_rank[g];
            if (w_do_insert && !w_le[g]) begin
                if (g == 0) begin
                    n_slot_value[g] = w_new_value;
                    n_slot_rank[g]  = r_item.entry_rank;
                end else if (w_le[(g == 0) ? 0 : g - 1]) begin
                    n_slot_value[g] = w_new_value;
                    n_slot_rank[g]  = r_item.entry_rank;
                end else begin
                    n_slot_value[g] = r_slot_value[(g == 0) ? 0 : g - 1];
                    n_slot_rank[g]  = r_slot_rank[(g == 0) ? 0 : g - 1];
                end
            end else if (w_do_remove && (g < CAPACITY - 1)) begin
                n_slot_value[g] = r_slot_value[(g < CAPACITY - 1) ? g + 1 : g];
                n_slot_rank[g]  = r_slot_rank[(g < CAPACITY - 1) ? g + 1 : g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_slot_value[g] <= n_slot_value[g];
            r_slot_rank[g]  <= n_slot_rank[g];
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_do_insert) begin
            n_count = r_count + CW'(1);
        end else if (w_do_remove) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out.head_value = '0;
        n_out.status     = ST_DONE;
        n_out.occupancy  = 5'(n_count);
        case (r_item.opcode)
            OP_INSERT: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end
            end
            OP_PEEK: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.head_value = 32'(r_slot_value[0]);
                end
            end
            default: begin
                n_out.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

// File: hdl/stable_min_priority_queue_core.sv
// An accepted input beat is captured, then applied in the execute state, where
// all slots compare and shift at once; execution waits while a result is
// pending, and no new beat is accepted until it finishes.
// Reset (synchronous, active low) empties the queue and clears both
// handshakes; slot contents are not reset and are never read before written.
// ----------------------------------------------------------------------------
// stable_min_priority_queue_core
// Sorted-slot priority queue with insert, remove-head and peek operations;
// equal ranks leave in arrival order. Controller plus datapath.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_core #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  smpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output smpq_pkg::t_out_item o_out_item
);
    import smpq_pkg::*;

    t_dp_cmd w_cmd;

    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    smpq_dpath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while previous beat still executing");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result beat raised without an executed operation");

    a_full_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_FULL))
            |-> (o_out_item.occupancy == 5'(CAPACITY)))
        else $error("full status with occupancy below capacity");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_EMPTY))
            |-> (o_out_item.occupancy == '0) && (o_out_item.head_value == '0))
        else $error("empty status with stored entries or head data");

endmodule
